// File: hdl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg - shared definitions of the radix string to integer unit
// Character codes, register indexes, parse phases and the digit lookup result.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int CHAR_W     = 8;
  localparam int NUM_SYMS   = 32;
  localparam int ALPHA_BITS = NUM_SYMS * CHAR_W;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_W      = 6;
  localparam int DIGIT_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_CHARS_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_CHARS_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_CHARS_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_CHARS_3 = 3'd4;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGIT,
    PH_DONE
  } phase_e;

  typedef logic [ALPHA_BITS-1:0] alpha_t;

  typedef struct packed {
    logic               hit;
    logic [DIGIT_W-1:0] index;
  } digit_t;

  function automatic logic is_blank(logic [CHAR_W-1:0] c);
    return c inside {CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE};
  endfunction

endpackage

// File: hdl/rsi_digit_lookup.sv
// ----------------------------------------------------------------------------
// rsi_digit_lookup - character to digit index
// Parallel compare of one character against the active alphabet symbols.
// ----------------------------------------------------------------------------
module rsi_digit_lookup #(
  parameter int MAX_RADIX = 32
) (
  input  logic [rsi_pkg::CHAR_W-1:0] char_i,
  input  rsi_pkg::alpha_t            alpha_i,
  input  logic [rsi_pkg::LEN_W-1:0]  len_i,
  output rsi_pkg::digit_t            digit_o
);
  import rsi_pkg::*;

  // Scan downward so the lowest matching position wins.
  always_comb begin
    digit_o = '0;
    for (int i = MAX_RADIX - 1; i >= 0; i--) begin
      if (char_i != CH_NUL && LEN_W'(i) < len_i &&
          alpha_i[CHAR_W*i +: CHAR_W] == char_i) begin
        digit_o.hit   = 1'b1;
        digit_o.index = DIGIT_W'(i);
      end
    end
  end

endmodule

// File: hdl/rsi_alpha_check.sv
// ----------------------------------------------------------------------------
// rsi_alpha_check - alphabet validation
// Flags a bad length, forbidden symbols and duplicate symbols.
// ----------------------------------------------------------------------------
module rsi_alpha_check #(
  parameter int MAX_RADIX = 32
) (
  input  logic [rsi_pkg::LEN_W-1:0] len_i,
  input  rsi_pkg::alpha_t           alpha_i,
  output logic                      ok_o
);
  import rsi_pkg::*;

  logic              bad;
  logic [CHAR_W-1:0] s;

  always_comb begin
    bad = 1'b0;
    s   = '0;
    for (int i = 0; i < MAX_RADIX; i++) begin
      if (LEN_W'(i) < len_i) begin
        s = alpha_i[CHAR_W*i +: CHAR_W];
        if (s == CH_NUL || is_blank(s) || s == CH_PLUS || s == CH_MINUS) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          if (LEN_W'(j) < len_i && alpha_i[CHAR_W*j +: CHAR_W] == s) begin
            bad = 1'b1;
          end
        end
      end
    end
    ok_o = !bad && (len_i >= LEN_W'(2)) && (len_i <= LEN_W'(MAX_RADIX));
  end

endmodule

// File: hdl/radix_string_to_integer_unit.sv
// ----------------------------------------------------------------------------
// radix_string_to_integer_unit - streaming text to integer parser
// Parses a signed integer from a character stream using a configurable
// digit alphabet; one result per text, on its last character.
// ----------------------------------------------------------------------------
//
//  channel  | dir | request contents
//  ---------+-----+--------------------------------------------------------
//  s_axis   | in  | tdata[7:0] char_in, tlast last_char
//  m_axis   | out | tdata[31:0] value, tdata[32] base_ok, tdata[39:33] zero
//  cfg      | in  | cfg_idx_i register index, cfg_wdata_i data, no read-back
//
//  One character per cycle unless a last character waits on an unread
//  result; requests pass the input register, results the result register,
//  set by one multiply-add per character in the parse stage.
//  Reset clears the configuration, the parse state and all valid flags.
//  A last character stalls in the input register while an unread result
//  waits; characters that are not last never wait on the output side.
//
module radix_string_to_integer_unit #(
  parameter int MAX_RADIX  = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side: tdata = {char_in}
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  input  logic                          s_axis_tlast,
  // master side: tdata = {pad, base_ok, value} from the lowest bit: value, base_ok
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [rsi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rsi_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import rsi_pkg::*;

  localparam int OUT_W   = 32;
  localparam int OUT_PAD = 40 - OUT_W - 1;

  // Configuration registers
  logic [LEN_W-1:0] base_length_q;
  logic [CFG_W-1:0] base_chars_q [4];
  alpha_t           alpha;
  logic [LEN_W-1:0] used_len;

  // Input register
  logic              s1_valid_q;
  logic [CHAR_W-1:0] s1_char_q;
  logic              s1_last_q;

  // Parse state; nacc_q always holds the two's complement of acc_q
  phase_e                phase_q, phase_d;
  phase_e                ph_a, ph_b, ph_c;
  logic                  neg_q, neg_d, neg_n;
  logic [VALUE_BITS-1:0] acc_q, acc_d, acc_n, acc_mul;
  logic [VALUE_BITS-1:0] nacc_q, nacc_d, nacc_n, nacc_mul;
  logic                  take_digit;

  // Result register
  logic             out_valid_q;
  logic [OUT_W-1:0] out_value_q, out_value_d;
  logic             out_ok_q;

  logic                  in_fire, s1_fire, out_free;
  digit_t                digit;
  logic                  alpha_ok;
  logic [VALUE_BITS-1:0] value_sel;

  // --------------------------------------------------------------------------
  // Configuration: ignore writes beyond the register list
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_length_q <= '0;
      for (int k = 0; k < 4; k++) base_chars_q[k] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE_LENGTH:  base_length_q   <= cfg_wdata_i[LEN_W-1:0];
        REG_BASE_CHARS_0: base_chars_q[0] <= cfg_wdata_i;
        REG_BASE_CHARS_1: base_chars_q[1] <= cfg_wdata_i;
        REG_BASE_CHARS_2: base_chars_q[2] <= cfg_wdata_i;
        REG_BASE_CHARS_3: base_chars_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign alpha    = {base_chars_q[3], base_chars_q[2], base_chars_q[1], base_chars_q[0]};
  // Clamp the radix to the supported alphabet size
  assign used_len = (base_length_q > LEN_W'(MAX_RADIX)) ? LEN_W'(MAX_RADIX) : base_length_q;

  rsi_digit_lookup #(.MAX_RADIX(MAX_RADIX)) u_lookup (
    .char_i  (s1_char_q),
    .alpha_i (alpha),
    .len_i   (used_len),
    .digit_o (digit)
  );

  rsi_alpha_check #(.MAX_RADIX(MAX_RADIX)) u_check (
    .len_i   (base_length_q),
    .alpha_i (alpha),
    .ok_o    (alpha_ok)
  );

  // --------------------------------------------------------------------------
  // Handshake: a non-last character always advances, a last one needs room
  // --------------------------------------------------------------------------
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_fire       = s1_valid_q && (!s1_last_q || out_free);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= s_axis_tdata;
      s1_last_q <= s_axis_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // Phase next state: skip blanks, then signs, then digits, then done
  // --------------------------------------------------------------------------
  always_comb begin
    ph_a = phase_q;
    if (phase_q == PH_SPACE && !is_blank(s1_char_q)) ph_a = PH_SIGN;
    ph_b = ph_a;
    if (ph_a == PH_SIGN && s1_char_q != CH_MINUS && s1_char_q != CH_PLUS) ph_b = PH_DIGIT;
    ph_c = ph_b;
    if (ph_b == PH_DIGIT && !digit.hit) ph_c = PH_DONE;
    // Return to the start after the last character of a text
    phase_d = s1_last_q ? PH_SPACE : ph_c;
  end

  // --------------------------------------------------------------------------
  // Datapath: sign flip and multiply-add on both acc and its negation
  // --------------------------------------------------------------------------
  assign acc_mul  = acc_q * VALUE_BITS'(used_len);
  assign nacc_mul = nacc_q * VALUE_BITS'(used_len);

  always_comb begin
    neg_n      = neg_q ^ (ph_a == PH_SIGN && s1_char_q == CH_MINUS);
    take_digit = (ph_b == PH_DIGIT) && digit.hit;
    acc_n      = take_digit ? acc_mul + VALUE_BITS'(digit.index) : acc_q;
    nacc_n     = take_digit ? nacc_mul - VALUE_BITS'(digit.index) : nacc_q;
    neg_d      = s1_last_q ? 1'b0 : neg_n;
    acc_d      = s1_last_q ? '0 : acc_n;
    nacc_d     = s1_last_q ? '0 : nacc_n;
    value_sel  = alpha_ok ? (neg_n ? nacc_n : acc_n) : '0;
  end

  // Fit the value into the 32-bit result field
  if (VALUE_BITS >= OUT_W) begin : g_trunc
    assign out_value_d = value_sel[OUT_W-1:0];
  end else begin : g_extend
    assign out_value_d = {{(OUT_W-VALUE_BITS){1'b0}}, value_sel};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      nacc_q  <= '0;
    end else if (s1_fire) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      nacc_q  <= nacc_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: load on a last character, drop when taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_value_q <= out_value_d;
      out_ok_q    <= alpha_ok;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_ok_q, out_value_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_neg_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    VALUE_BITS'(acc_q + nacc_q) == VALUE_BITS'(0))
    else $error("negated accumulator out of step");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> (phase_q == PH_SPACE && !neg_q && acc_q == '0))
    else $error("parse state not cleared after last character");

  a_bad_alpha_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[OUT_W]) |-> (m_axis_tdata[OUT_W-1:0] == '0))
    else $error("nonzero value with invalid alphabet");

  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q && out_valid_q && !m_axis_tready) |=> s1_valid_q)
    else $error("last character lost while result stalled");

endmodule

// File: test/tb_radix_string_to_integer_unit.sv
// ----------------------------------------------------------------------------
// tb_radix_string_to_integer_unit - regression of the radix string parser
// Streams texts one character per request into the parser and checks every
// parsed value and alphabet flag against typed-in results or a behavioral
// predictor. A short directed table is followed by randomized alphabets and
// texts under several source and sink throttling patterns.
// ----------------------------------------------------------------------------
module tb_radix_string_to_integer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rsi_pkg::*;

  localparam int LIMIT_CYCLES     = 400000;
  localparam int SETTLE_CYCLES    = 4;   // input and result register, plus margin
  localparam int TEXT_PHASES      = 12;
  localparam int CHARS_PER_PHASE  = 145;
  localparam int SHOWN_MISMATCHES = 10;

  // Parsed integer as it leaves the master side.
  typedef struct packed {
    logic signed [31:0] value;
    logic               base_ok;
  } int_result_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_CHAR
  } row_kind_e;

  // One line of the directed table: a register write or one character.
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      data;
    logic [CHAR_W-1:0]     ch;
    logic                  is_last;
    logic                  typed;
    int_result_t           result;
  } text_row_t;

  // Ways to spoil a random alphabet.
  typedef enum int {
    FLAW_NONE,
    FLAW_DUPLICATE,
    FLAW_FORBIDDEN,
    FLAW_LENGTH,
    FLAW_RAW
  } flaw_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;   // char_in
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;         // value[31:0], base_ok[32], zero pad
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;

  radix_string_to_integer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Parser prediction: shadow registers and parse state
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0] radix_reg       = '0;
  logic [CFG_W-1:0] symbol_regs [4] = '{default: '0};
  phase_e           text_phase      = PH_SPACE;
  logic             text_negative   = 1'b0;
  logic [31:0]      text_acc        = '0;

  int_result_t pending_results [$];
  text_row_t   directed_rows [$];
  int          fail_count     = 0;
  int          chars_sent     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  function automatic logic [7:0] symbol(int i);
    return symbol_regs[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic logic white(logic [7:0] c);
    return c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
           c == CH_CR || c == CH_SPACE;
  endfunction

  // Digits are looked up in at most NUM_SYMS symbols, whatever the length says.
  function automatic int live_radix();
    return (radix_reg > NUM_SYMS) ? NUM_SYMS : int'(radix_reg);
  endfunction

  function automatic logic alphabet_valid();
    int          n;
    logic [7:0]  s;
    n = int'(radix_reg);
    if (n < 2 || n > NUM_SYMS) return 1'b0;
    for (int i = 0; i < n; i++) begin
      s = symbol(i);
      if (s == CH_NUL || white(s) || s == CH_PLUS || s == CH_MINUS) return 1'b0;
      for (int j = i + 1; j < n; j++) begin
        if (symbol(j) == s) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic int digit_value(logic [7:0] c);
    if (c == CH_NUL) return -1;
    for (int i = 0; i < live_radix(); i++) begin
      if (symbol(i) == c) return i;
    end
    return -1;
  endfunction

  // Advance the parse by one character; return 1 when a result is produced.
  function automatic logic parse_char(input logic [7:0] c, input logic is_last,
                                      output int_result_t res);
    int d;
    if (text_phase == PH_SPACE && !white(c)) text_phase = PH_SIGN;
    if (text_phase == PH_SIGN) begin
      if (c == CH_MINUS) text_negative = !text_negative;
      else if (c != CH_PLUS) text_phase = PH_DIGIT;
    end
    if (text_phase == PH_DIGIT) begin
      d = digit_value(c);
      if (d >= 0) text_acc = text_acc * 32'(live_radix()) + 32'(d);
      else text_phase = PH_DONE;
    end
    res = '0;
    if (!is_last) return 1'b0;
    res.base_ok = alphabet_valid();
    if (res.base_ok) res.value = text_negative ? -text_acc : text_acc;
    text_phase    = PH_SPACE;
    text_negative = 1'b0;
    text_acc      = '0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_LF;
      2: return CH_VT;
      3: return CH_FF;
      4: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic text_row_t write_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    return '{ROW_WRITE, idx, data, CH_NUL, 1'b0, 1'b0, '0};
  endfunction

  function automatic text_row_t char_row(logic [7:0] c);
    return '{ROW_CHAR, REG_BASE_LENGTH, '0, c, 1'b0, 1'b0, '0};
  endfunction

  // Closing character with the result typed in.
  function automatic text_row_t checked_row(logic [7:0] c, int value, logic ok);
    return '{ROW_CHAR, REG_BASE_LENGTH, '0, c, 1'b1, 1'b1, '{value, ok}};
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Drive the write across a clock edge and mirror it into the shadow registers.
  // The caller drops the write enable once its batch is done.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == REG_BASE_LENGTH) radix_reg = data[LEN_W-1:0];
    else if (idx <= REG_BASE_CHARS_3) symbol_regs[idx - REG_BASE_CHARS_0] = data;
  endtask

  // Offer one character request and hold it until the parser takes it.
  task automatic send_char(logic [7:0] c, logic is_last, logic typed, int_result_t typed_res);
    int_result_t res;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    chars_sent++;
    if (parse_char(c, is_last, res)) pending_results.push_back(typed ? typed_res : res);
  endtask

  // Stop sending, wait out every outstanding result, then let the pipe settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Build 32 distinct legal symbols, spoil them as asked, and write all registers.
  task automatic program_alphabet(int radix, flaw_e flaw);
    logic [7:0]       syms [NUM_SYMS];
    logic [7:0]       c;
    logic             clash;
    logic [CFG_W-1:0] word;
    int               n;
    int               k;
    n = 0;
    while (n < NUM_SYMS) begin
      c     = 8'($urandom_range(1, 255));
      clash = white(c) || c == CH_PLUS || c == CH_MINUS;
      for (k = 0; k < n; k++) if (syms[k] == c) clash = 1'b1;
      if (!clash) begin
        syms[n] = c;
        n++;
      end
    end
    k = $urandom_range(0, radix - 1);
    case (flaw)
      FLAW_DUPLICATE: syms[k] = syms[(k + 1) % radix];
      FLAW_FORBIDDEN: begin
        case ($urandom_range(0, 3))
          0: syms[k] = CH_NUL;
          1: syms[k] = pick_blank();
          2: syms[k] = CH_PLUS;
          default: syms[k] = CH_MINUS;
        endcase
      end
      FLAW_LENGTH: begin
        radix = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(NUM_SYMS + 1, 63);
      end
      default: ;
    endcase
    // upper bits of the length write are junk and must be dropped
    word = {$urandom, $urandom};
    word[LEN_W-1:0] = LEN_W'(radix);
    write_reg(REG_BASE_LENGTH, word);
    for (k = 0; k < 4; k++) begin
      for (n = 0; n < 8; n++) word[n * 8 +: 8] = syms[k * 8 + n];
      if (flaw == FLAW_RAW) word = {$urandom, $urandom};
      write_reg(REG_BASE_CHARS_0 + CFG_IDX_W'(k), word);
    end
    // a write past the register list must leave everything as it is
    if ($urandom_range(0, 1)) begin
      write_reg(REG_BASE_CHARS_3 + CFG_IDX_W'($urandom_range(1, 3)), {$urandom, $urandom});
    end
    cfg_we_i <= 1'b0;
  endtask

  // One text: mostly well formed (blanks, signs, digits, maybe junk), sometimes noise.
  task automatic send_text();
    logic [7:0] text [$];
    logic       noise;
    logic       closing;
    int         n;
    n     = (live_radix() < 1) ? 1 : live_radix();
    noise = ($urandom_range(0, 7) == 0);
    if (noise) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 3)) text.push_back(pick_blank());
      repeat ($urandom_range(0, 3)) text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      repeat ($urandom_range(0, 12)) text.push_back(symbol($urandom_range(0, n - 1)));
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) text.push_back(8'($urandom));
      if (text.size() == 0) text.push_back(symbol(0));
    end
    // noise may leave the text open; the next text then continues it
    closing = noise ? 1'($urandom_range(0, 1)) : 1'b1;
    foreach (text[k]) send_char(text[k], closing && k == text.size() - 1, 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Sink: random backpressure and result checking
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    int_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOWN_MISMATCHES) begin
          $display("unexpected result: value %0d base_ok %0b",
                   $signed(m_axis_tdata[31:0]), m_axis_tdata[32]);
        end
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.value || m_axis_tdata[32] !== want.base_ok) begin
          fail_count++;
          if (fail_count <= SHOWN_MISMATCHES) begin
            $display("result mismatch: value %0d base_ok %0b, expected value %0d base_ok %0b",
                     $signed(m_axis_tdata[31:0]), m_axis_tdata[32], want.value, want.base_ok);
          end
        end
      end
    end
  end

  // Cycle budget: drop the run if the parser hangs.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("radix_string_to_integer_unit regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int    goal;
    int    radix;
    flaw_e flaw;
    logic  held;
    logic  prior_write;

    directed_rows = '{
      // registers still at reset: length 0 means an invalid alphabet
      checked_row("5", 0, 1'b0),
      // decimal alphabet
      write_row(REG_BASE_LENGTH, 64'd10),
      write_row(REG_BASE_CHARS_0, 64'h3736_3534_3332_3130),
      write_row(REG_BASE_CHARS_1, 64'h0000_0000_0000_3938),
      // every blank, then a sign run with three minus signs, digits, then a non-digit
      char_row(CH_SPACE), char_row(CH_TAB), char_row(CH_LF), char_row(CH_VT),
      char_row(CH_FF), char_row(CH_CR), char_row(CH_MINUS), char_row(CH_PLUS),
      char_row(CH_MINUS), char_row(CH_MINUS), char_row("4"), char_row("2"),
      checked_row("x", -42, 1'b1),
      // a zero byte ends the number
      char_row("7"), checked_row(CH_NUL, 7, 1'b1),
      // radix 32 over the top byte values; junk above the length field
      write_row(REG_BASE_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0),
      write_row(REG_BASE_CHARS_0, 64'hE7E6_E5E4_E3E2_E1E0),
      write_row(REG_BASE_CHARS_1, 64'hEFEE_EDEC_EBEA_E9E8),
      write_row(REG_BASE_CHARS_2, 64'hF7F6_F5F4_F3F2_F1F0),
      write_row(REG_BASE_CHARS_3, 64'hFFFE_FDFC_FBFA_F9F8),
      // writes past the register list are ignored
      write_row(REG_BASE_CHARS_3 + 3'd1, '0),
      write_row(REG_BASE_CHARS_3 + 3'd2, '0),
      write_row(REG_BASE_CHARS_3 + 3'd3, '0),
      // seven top digits wrap to all ones
      char_row(8'hFF), char_row(8'hFF), char_row(8'hFF), char_row(8'hFF),
      char_row(8'hFF), char_row(8'hFF), checked_row(8'hFF, -1, 1'b1),
      // invalid alphabets: too short, too long, duplicate, sign symbol
      write_row(REG_BASE_LENGTH, 64'd1), checked_row(8'hE1, 0, 1'b0),
      write_row(REG_BASE_LENGTH, 64'd40), checked_row(8'hE1, 0, 1'b0),
      write_row(REG_BASE_LENGTH, 64'd32),
      write_row(REG_BASE_CHARS_3, 64'hFFFE_FDFC_FBFA_F9E0), checked_row(8'hE1, 0, 1'b0),
      write_row(REG_BASE_CHARS_3, 64'hFFFE_FDFC_FBFA_2BF8), checked_row(8'hE1, 0, 1'b0)
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; write registers only with the parser idle.
    prior_write = 1'b0;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        if (!prior_write) drain();
        write_reg(directed_rows[r].idx, directed_rows[r].data);
        prior_write = 1'b1;
      end else begin
        cfg_we_i <= 1'b0;
        send_char(directed_rows[r].ch, directed_rows[r].is_last,
                  directed_rows[r].typed, directed_rows[r].result);
        prior_write = 1'b0;
      end
    end
    drain();

    // Random part: a new alphabet per phase, throttling rotating through four modes.
    held = 1'b0;
    for (int p = 0; p < TEXT_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      radix = (p == 0) ? 2 : (p == 1) ? NUM_SYMS : $urandom_range(2, NUM_SYMS);
      flaw  = (p >= 2 && $urandom_range(0, 3) == 0) ? flaw_e'($urandom_range(1, 4)) : FLAW_NONE;
      program_alphabet(radix, flaw);
      goal = chars_sent + CHARS_PER_PHASE;
      while (chars_sent < goal) begin
        send_text();
        // once, hold the source mid-phase until every result is back
        if (p == TEXT_PHASES / 2 && !held && chars_sent >= goal - CHARS_PER_PHASE / 2) begin
          drain();
          held = 1'b1;
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("radix_string_to_integer_unit regression: pass");
    end else begin
      $display("radix_string_to_integer_unit regression: fail");
    end
    $finish;
  end

endmodule
